// ===== src/svalloc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sound voice allocator package
// Request, response and voice entry types, function codes and time limits.
// ----------------------------------------------------------------------------
package svalloc_pkg;

  localparam int unsigned EntW  = 10;
  localparam int unsigned SubW  = 8;
  localparam int unsigned LenW  = 24;
  localparam int unsigned TimeW = 31;
  localparam int unsigned RelW  = 5;
  localparam int unsigned LeftW = TimeW + 1;

  localparam logic [1:0] FUNC_ALLOC    = 2'd0;
  localparam logic [1:0] FUNC_RELEASE  = 2'd1;
  localparam logic [1:0] FUNC_STOP_ALL = 2'd2;

  localparam logic [TimeW-1:0]        TIME_MAX  = 31'h7fffffff;
  localparam logic signed [LeftW-1:0] LEFT_INIT = 32'sh7fffffff;
  localparam logic [EntW-1:0]         PLAYER_RESET = 10'd1;

  typedef struct packed {
    logic [1:0]       func;
    logic [EntW-1:0]  entity;
    logic [SubW-1:0]  sub_channel;
    logic [LenW-1:0]  sound_length;
    logic [TimeW-1:0] now;
    logic [RelW-1:0]  release_index;
  } req_t;

  typedef struct packed {
    logic            granted;
    logic [RelW-1:0] voice_index;
    logic            overrode_same_owner;
  } rsp_t;

  typedef struct packed {
    logic [EntW-1:0]  entity;
    logic [SubW-1:0]  sub_channel;
    logic [TimeW-1:0] end_time;
    logic             active;
  } voice_t;

  localparam int unsigned VoiceW = $bits(voice_t);

endpackage

// ===== src/sound_voice_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Sound voice allocator
// Voice-stealing allocator over a table of mixer voices held in one RAM.
// ----------------------------------------------------------------------------
// An allocate transaction scans the voice RAM one entry per cycle and ends
// with the result strobe; a same-owner hit ends the scan early. The single
// RAM read port sets this rate. Release, stop-all and unused codes finish
// without a scan and without raising busy. Each result is on rsp_o for
// exactly one cycle with done_o high and cannot be held off; a new
// transaction may start while it shows.
module sound_voice_allocator_unit #(
  parameter int unsigned VOICES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  svalloc_pkg::req_t   req_i,
  output logic                busy,
  input  logic                cfg_we_i,
  input  logic [9:0]          cfg_wdata_i,
  output logic                done_o,
  output svalloc_pkg::rsp_t   rsp_o
);
  import svalloc_pkg::*;

  localparam int unsigned IdxW = $clog2(VOICES);
  localparam int unsigned CntW = $clog2(VOICES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(VOICES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]              state_q, state_d;
  req_t                    req_q, req_d;
  logic [EntW-1:0]         player_q, player_d;
  logic [VOICES-1:0]       valid_q, valid_d;
  logic [CntW-1:0]         rd_cnt_q, rd_cnt_d;
  logic [IdxW-1:0]         cmp_idx_q, cmp_idx_d;
  logic                    rd_valid_q, rd_valid_d;
  logic [IdxW-1:0]         pick_q, pick_d;
  logic                    found_q, found_d;
  logic                    same_q, same_d;
  logic signed [LeftW-1:0] best_q, best_d;
  logic                    done_q, done_d;
  rsp_t                    rsp_q, rsp_d;

  logic [IdxW-1:0]         raddr;
  logic                    ram_we;
  voice_t                  wdata;
  logic [VoiceW-1:0]       rdata;
  voice_t                  cur;
  logic                    same_hit;
  logic                    protect;
  logic signed [LeftW-1:0] left;
  logic                    better;
  logic [LeftW-1:0]        end_sum;
  logic [TimeW-1:0]        end_new;

  svalloc_ram #(
    .Width(VoiceW),
    .Depth(VOICES)
  ) u_voice_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pick_q),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign cur      = rd_valid_q ? voice_t'(rdata) : '0;
  assign same_hit = (req_q.sub_channel != '0) && (cur.entity == req_q.entity)
                    && (cur.sub_channel == req_q.sub_channel);
  assign protect  = (cur.entity == player_q) && (req_q.entity != player_q) && cur.active;
  assign left     = signed'({1'b0, cur.end_time}) - signed'({1'b0, req_q.now});
  assign better   = !protect && (left < best_q);
  assign end_sum  = {1'b0, req_q.now} + LeftW'(req_q.sound_length);
  assign end_new  = end_sum[LeftW-1] ? TIME_MAX : end_sum[TimeW-1:0];

  always_comb begin
    wdata.entity      = req_q.entity;
    wdata.sub_channel = req_q.sub_channel;
    wdata.end_time    = end_new;
    wdata.active      = 1'b1;
  end

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    player_d   = player_q;
    valid_d    = valid_q;
    rd_cnt_d   = rd_cnt_q;
    pick_d     = pick_q;
    found_d    = found_q;
    same_d     = same_q;
    best_d     = best_q;
    done_d     = 1'b0;
    rsp_d      = '0;
    ram_we     = 1'b0;
    raddr      = (32'(rd_cnt_q) < VOICES) ? rd_cnt_q[IdxW-1:0] : '0;
    cmp_idx_d  = raddr;
    rd_valid_d = valid_q[raddr];

    if (cfg_we_i) begin
      player_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d = req_i;
          unique case (req_i.func)
            FUNC_ALLOC: begin
              state_d  = ST_SCAN;
              rd_cnt_d = CntW'(1);
              best_d   = LEFT_INIT;
              found_d  = 1'b0;
              same_d   = 1'b0;
              pick_d   = '0;
            end
            FUNC_RELEASE: begin
              if (32'(req_i.release_index) < VOICES) begin
                valid_d[IdxW'(req_i.release_index)] = 1'b0;
                rsp_d.granted = 1'b1;
              end
              rsp_d.voice_index = req_i.release_index;
              done_d = 1'b1;
            end
            FUNC_STOP_ALL: begin
              valid_d       = '0;
              rsp_d.granted = 1'b1;
              done_d        = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (32'(rd_cnt_q) < VOICES) begin
          rd_cnt_d = rd_cnt_q + CntW'(1);
        end
        if (same_hit) begin
          pick_d   = cmp_idx_q;
          same_d   = 1'b1;
          found_d  = 1'b1;
          rd_cnt_d = '0;
          state_d  = ST_WRITE;
        end else begin
          if (better) begin
            best_d  = left;
            pick_d  = cmp_idx_q;
            found_d = 1'b1;
          end
          if (cmp_idx_q == LastIdx) begin
            rd_cnt_d = '0;
            if (better || found_q) begin
              state_d = ST_WRITE;
            end else begin
              state_d = ST_IDLE;
              done_d  = 1'b1;
            end
          end
        end
      end
      ST_WRITE: begin
        ram_we                    = 1'b1;
        valid_d[pick_q]           = 1'b1;
        done_d                    = 1'b1;
        rsp_d.granted             = 1'b1;
        rsp_d.voice_index         = RelW'(pick_q);
        rsp_d.overrode_same_owner = same_q;
        state_d                   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      player_q   <= PLAYER_RESET;
      valid_q    <= '0;
      rd_cnt_q   <= '0;
      cmp_idx_q  <= '0;
      rd_valid_q <= 1'b0;
      found_q    <= 1'b0;
      same_q     <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      player_q   <= player_d;
      valid_q    <= valid_d;
      rd_cnt_q   <= rd_cnt_d;
      cmp_idx_q  <= cmp_idx_d;
      rd_valid_q <= rd_valid_d;
      found_q    <= found_d;
      same_q     <= same_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pick_q <= pick_d;
    best_q <= best_d;
    rsp_q  <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a scan is running");

  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |=> done_o && rsp_o.granted && !busy)
    else $error("voice write not followed by a granted result");

  a_same_granted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.overrode_same_owner) |-> rsp_o.granted)
    else $error("same-owner override without grant");

  a_stop_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.func == FUNC_STOP_ALL) |=> done_o && (valid_q == '0))
    else $error("stop-all left voices valid");

endmodule

// ===== src/svalloc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module svalloc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
